[design/dtct_pkg.sv]
package dtct_pkg;

  localparam int ID_W  = 7;
  localparam int POS_W = 12;

  // Raw pad value offset: signed two's complement to 0..65535
  localparam logic [15:0] RAW_OFFSET = 16'h8000;
  // Full-scale raw span; n / 65535 is taken as (n >> 16) plus one correction
  localparam logic [16:0] SCALE_DIV  = 17'd65535;
  localparam logic [9:0]  Y_SPAN     = 10'd800;
  localparam logic [25:0] Y_CEIL_ADD = 26'd65534;
  localparam logic [POS_W-1:0] RIGHT_X_OFFSET = 12'd1024;

  // Touch pair codes: bit 1 left pad, bit 0 right pad
  localparam logic [1:0] PAIR_NONE  = 2'b00;
  localparam logic [1:0] PAIR_RIGHT = 2'b01;
  localparam logic [1:0] PAIR_LEFT  = 2'b10;

  typedef struct packed {
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] x;
  } dtct_pos_t;

  typedef struct packed {
    logic               left_touch;
    logic               right_touch;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         time_increment;
  } dtct_in_t;

  typedef struct packed {
    logic [7:0]  finger_one_status;
    logic [23:0] finger_one_position;
    logic [7:0]  finger_two_status;
    logic [23:0] finger_two_position;
    logic [7:0]  touch_time;
  } dtct_out_t;

  // Scaled report waiting between the pad lanes and the slot tracker
  typedef struct packed {
    logic       left_touch;
    logic       right_touch;
    dtct_pos_t  left_pos;
    dtct_pos_t  right_pos;
    logic [7:0] time_increment;
  } dtct_stage_t;

endpackage

[design/dtct_lane.sv]
module dtct_lane (
  input  logic                clk,
  input  logic                load,
  input  logic signed [15:0]  raw_x,
  input  logic signed [15:0]  raw_y,
  output dtct_pkg::dtct_pos_t pos_r
);

  logic [15:0] ux;
  logic [15:0] uy;
  logic [9:0]  xq0;
  logic [16:0] xr0;
  logic [10:0] xq;
  logic [25:0] yn;
  logic [9:0]  yq0;
  logic [16:0] yr0;
  logic [9:0]  yq;
  logic [9:0]  y;
  dtct_pkg::dtct_pos_t pos_nxt;

  always_comb begin
    ux = unsigned'(raw_x) ^ dtct_pkg::RAW_OFFSET;
    uy = unsigned'(raw_y) ^ dtct_pkg::RAW_OFFSET;

    // x = floor(u*1024 / 65535); remainder of the shift estimate stays below 2*65535
    xq0 = ux[15:6];
    xr0 = {1'b0, ux[5:0], 10'b0} + {7'b0, xq0};
    xq  = {1'b0, xq0} + {10'b0, (xr0 >= dtct_pkg::SCALE_DIV)};

    // y = 800 - ceil(u*800 / 65535)
    yn  = 26'(uy) * 26'(dtct_pkg::Y_SPAN) + dtct_pkg::Y_CEIL_ADD;
    yq0 = yn[25:16];
    yr0 = {1'b0, yn[15:0]} + {7'b0, yq0};
    yq  = yq0 + {9'b0, (yr0 >= dtct_pkg::SCALE_DIV)};
    y   = dtct_pkg::Y_SPAN - yq;

    pos_nxt.x = {1'b0, xq};
    pos_nxt.y = {2'b0, y};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

[design/dtct_merge.sv]
module dtct_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s_valid,
  input  dtct_pkg::dtct_stage_t s_item,
  output logic                  s_ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dtct_pkg::dtct_out_t   out_item
);

  logic                         out_valid_r;
  dtct_pkg::dtct_out_t          out_item_r;
  dtct_pkg::dtct_out_t          out_item_nxt;
  logic                         lif_r;
  logic                         lif_nxt;
  logic [1:0]                   prev_r;
  logic [1:0]                   pair;
  logic [1:0]                   was_r;
  logic [dtct_pkg::ID_W-1:0]    id_r [2];
  logic [dtct_pkg::ID_W-1:0]    id_nxt [2];
  dtct_pkg::dtct_pos_t          saved_r [2];
  dtct_pkg::dtct_pos_t          saved_nxt [2];
  logic [1:0]                   touch;
  dtct_pkg::dtct_pos_t          pos [2];
  dtct_pkg::dtct_pos_t          right_pos;
  logic [7:0]                   status [2];
  logic [7:0]                   time_r;
  logic [7:0]                   time_nxt;
  logic                         adv;

  assign s_ready   = !out_valid_r || !out_stall;
  assign adv       = s_valid && s_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    pair = {s_item.left_touch, s_item.right_touch};
    right_pos.y = s_item.right_pos.y;
    right_pos.x = s_item.right_pos.x + dtct_pkg::RIGHT_X_OFFSET;

    // Pick finger order on a single-pad touch out of a fully idle state
    lif_nxt = lif_r;
    if (prev_r == dtct_pkg::PAIR_NONE && pair == dtct_pkg::PAIR_RIGHT) begin
      lif_nxt = 1'b0;
    end
    if (prev_r == dtct_pkg::PAIR_NONE && pair == dtct_pkg::PAIR_LEFT) begin
      lif_nxt = 1'b1;
    end

    touch[0] = lif_nxt ? s_item.left_touch : s_item.right_touch;
    touch[1] = lif_nxt ? s_item.right_touch : s_item.left_touch;
    pos[0]   = lif_nxt ? s_item.left_pos : right_pos;
    pos[1]   = lif_nxt ? right_pos : s_item.left_pos;

    for (int s = 0; s < 2; s++) begin
      id_nxt[s]    = id_r[s];
      saved_nxt[s] = saved_r[s];
      if (touch[s]) begin
        saved_nxt[s] = pos[s];
        status[s]    = {1'b0, id_r[s]};
      end else begin
        // advance the contact id on release
        if (was_r[s]) begin
          id_nxt[s] = id_r[s] + 7'd1;
        end
        status[s] = {1'b1, id_nxt[s]};
      end
    end

    time_nxt = (pair != dtct_pkg::PAIR_NONE) ? time_r + s_item.time_increment : time_r;

    out_item_nxt.finger_one_status   = status[0];
    out_item_nxt.finger_one_position = saved_nxt[0];
    out_item_nxt.finger_two_status   = status[1];
    out_item_nxt.finger_two_position = saved_nxt[1];
    out_item_nxt.touch_time          = time_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      lif_r       <= 1'b1;
      prev_r      <= dtct_pkg::PAIR_NONE;
      was_r       <= 2'b00;
      time_r      <= 8'd0;
      for (int s = 0; s < 2; s++) begin
        id_r[s]    <= '0;
        saved_r[s] <= '0;
      end
    end else begin
      out_valid_r <= adv || (out_valid_r && out_stall);
      if (adv) begin
        lif_r  <= lif_nxt;
        prev_r <= pair;
        was_r  <= touch;
        time_r <= time_nxt;
        for (int s = 0; s < 2; s++) begin
          id_r[s]    <= id_nxt[s];
          saved_r[s] <= saved_nxt[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= out_item_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_time_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && pair == dtct_pkg::PAIR_NONE |=> $stable(time_r))
    else $error("touch time moved on an untouched report");

  a_id_step0: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> id_r[0] == $past(id_r[0]) || id_r[0] == $past(id_r[0]) + 7'd1)
    else $error("finger one contact id jumped");

  a_id_step1: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> id_r[1] == $past(id_r[1]) || id_r[1] == $past(id_r[1]) + 7'd1)
    else $error("finger two contact id jumped");

  a_both_touch: assert property (@(posedge clk) disable iff (!rst_n)
    adv && pair == 2'b11 |=>
      !out_item_r.finger_one_status[7] && !out_item_r.finger_two_status[7])
    else $error("touching finger reported idle");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_item_r) && $stable(time_r))
    else $error("stalled result or tracker state changed");
`endif

endmodule

[design/dual_touchpad_contact_tracker.sv]
// Path: a report accepted into the lane registers moves on to the merge output
// register that drives out_valid once the merge stage takes it; out_stall can hold it back.
// Throughput: one report per cycle; a new report is taken every cycle that
// the output side keeps up, and one more is held while a result waits.
// Reset (rst_n low, synchronous): pipeline empties, left pad drives finger one,
// contact ids, saved positions and the touch time byte clear to zero.
module dual_touchpad_contact_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtct_pkg::dtct_in_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dtct_pkg::dtct_out_t out_item
);

  logic                  s1_valid_r;
  logic                  s1_load;
  logic                  s_ready;
  logic                  left_touch_r;
  logic                  right_touch_r;
  logic [7:0]            time_inc_r;
  dtct_pkg::dtct_pos_t   left_pos_r;
  dtct_pkg::dtct_pos_t   right_pos_r;
  dtct_pkg::dtct_stage_t s1_item;

  assign in_stall = s1_valid_r && !s_ready;
  assign s1_load  = in_valid && !in_stall;

  dtct_lane u_left_lane (
    .clk   (clk),
    .load  (s1_load),
    .raw_x (in_item.left_x),
    .raw_y (in_item.left_y),
    .pos_r (left_pos_r)
  );

  dtct_lane u_right_lane (
    .clk   (clk),
    .load  (s1_load),
    .raw_x (in_item.right_x),
    .raw_y (in_item.right_y),
    .pos_r (right_pos_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_load || (s1_valid_r && !s_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      left_touch_r  <= in_item.left_touch;
      right_touch_r <= in_item.right_touch;
      time_inc_r    <= in_item.time_increment;
    end
  end

  always_comb begin
    s1_item.left_touch     = left_touch_r;
    s1_item.right_touch    = right_touch_r;
    s1_item.left_pos       = left_pos_r;
    s1_item.right_pos      = right_pos_r;
    s1_item.time_increment = time_inc_r;
  end

  dtct_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (s1_valid_r),
    .s_item    (s1_item),
    .s_ready   (s_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  dtct_pkg::dtct_in_t  in_item = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  dtct_pkg::dtct_out_t out_item;

  dual_touchpad_contact_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Tracker model state
  bit                  lead_is_left;
  logic [1:0]          last_pair;
  bit                  slot_active [2];
  logic [6:0]          slot_id [2];
  dtct_pkg::dtct_pos_t slot_pos [2];
  logic [7:0]          touch_clock;

  dtct_pkg::dtct_out_t pending_reports [$];
  int                  mismatch_count = 0;
  int                  reports_sent = 0;

  // Idle control for both sides of the block
  bit tx_gaps_on = 1'b0;
  bit rx_gaps_on = 1'b0;
  int hold_left = 0;
  int burst_left = 0;

  function automatic dtct_pkg::dtct_pos_t map_pad(logic [15:0] raw_x, logic [15:0] raw_y,
                                                  bit right_pad);
    int unsigned         ux;
    int unsigned         uy;
    int unsigned         x;
    int unsigned         y;
    dtct_pkg::dtct_pos_t p;
    ux = {16'h0, raw_x ^ 16'h8000};
    uy = {16'h0, raw_y ^ 16'h8000};
    x = (ux * 1024) / 65535;
    if (right_pad) x = x + 1024;
    y = 800 - (uy * 800 + 65534) / 65535;
    p.x = x[11:0];
    p.y = y[11:0];
    return p;
  endfunction

  task automatic advance_slot(input int s, input bit touch, input dtct_pkg::dtct_pos_t pos,
                              output logic [7:0] status, output logic [23:0] position);
    if (touch) begin
      slot_pos[s] = pos;
      status = {1'b0, slot_id[s]};
    end else begin
      if (slot_active[s]) slot_id[s] = slot_id[s] + 7'd1;
      status = {1'b1, slot_id[s]};
    end
    position = slot_pos[s];
    slot_active[s] = touch;
  endtask

  task automatic track_report(input dtct_pkg::dtct_in_t r);
    logic [1:0]          pair;
    dtct_pkg::dtct_pos_t lpos;
    dtct_pkg::dtct_pos_t rpos;
    dtct_pkg::dtct_out_t want;
    pair = {r.left_touch, r.right_touch};
    lpos = map_pad(r.left_x, r.left_y, 1'b0);
    rpos = map_pad(r.right_x, r.right_y, 1'b1);
    // pad order only changes when a single pad lands out of full idle
    if (last_pair == dtct_pkg::PAIR_NONE && pair == dtct_pkg::PAIR_RIGHT) lead_is_left = 1'b0;
    if (last_pair == dtct_pkg::PAIR_NONE && pair == dtct_pkg::PAIR_LEFT) lead_is_left = 1'b1;
    last_pair = pair;
    if (lead_is_left) begin
      advance_slot(0, r.left_touch, lpos, want.finger_one_status, want.finger_one_position);
      advance_slot(1, r.right_touch, rpos, want.finger_two_status, want.finger_two_position);
    end else begin
      advance_slot(0, r.right_touch, rpos, want.finger_one_status, want.finger_one_position);
      advance_slot(1, r.left_touch, lpos, want.finger_two_status, want.finger_two_position);
    end
    if (pair != dtct_pkg::PAIR_NONE) touch_clock = touch_clock + r.time_increment;
    want.touch_time = touch_clock;
    pending_reports.push_back(want);
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    dtct_pkg::dtct_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_item);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("finger_one_status", 24'(want.finger_one_status),
                    24'(out_item.finger_one_status));
        check_field("finger_one_position", want.finger_one_position,
                    out_item.finger_one_position);
        check_field("finger_two_status", 24'(want.finger_two_status),
                    24'(out_item.finger_two_status));
        check_field("finger_two_position", want.finger_two_position,
                    out_item.finger_two_position);
        check_field("touch_time", 24'(want.touch_time), 24'(out_item.touch_time));
      end
    end
  end

  // Receiver side: long hold-off first, then random stall bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (burst_left > 0) begin
      out_stall = 1'b1;
      burst_left--;
    end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
      out_stall = 1'b1;
      burst_left = $urandom_range(1, 8) - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  task automatic send_report(input dtct_pkg::dtct_in_t r);
    int gap;
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item = r;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    track_report(r);
    reports_sent++;
    @(negedge clk);
  endtask

  // Hold input idle until every transaction has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  function automatic dtct_pkg::dtct_in_t make_pads(bit lt, bit rt, logic [15:0] lx,
                                                   logic [15:0] ly, logic [15:0] rx,
                                                   logic [15:0] ry, logic [7:0] ti);
    dtct_pkg::dtct_in_t r;
    r.left_touch = lt;
    r.right_touch = rt;
    r.left_x = lx;
    r.left_y = ly;
    r.right_x = rx;
    r.right_y = ry;
    r.time_increment = ti;
    return r;
  endfunction

  function automatic dtct_pkg::dtct_in_t make_report(bit lt, bit rt);
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = $urandom;
    return make_pads(lt, rt, a[15:0], a[31:16], b[15:0], b[31:16],
                     8'($urandom_range(0, 255)));
  endfunction

  // One touch gesture: first pad lands, maybe a second joins, release, settle idle
  task automatic play_gesture();
    bit first_right;
    bit first_lifts;
    first_right = 1'($urandom_range(0, 1));
    repeat ($urandom_range(1, 6)) send_report(make_report(!first_right, first_right));
    if ($urandom_range(0, 2) != 0) begin
      repeat ($urandom_range(1, 6)) send_report(make_report(1'b1, 1'b1));
      first_lifts = 1'($urandom_range(0, 1));
      if (first_lifts)
        repeat ($urandom_range(1, 4)) send_report(make_report(first_right, !first_right));
      else
        repeat ($urandom_range(1, 4)) send_report(make_report(!first_right, first_right));
    end
    repeat ($urandom_range(1, 3)) send_report(make_report(1'b0, 1'b0));
  endtask

  task automatic play_noise(input int n);
    repeat (n) send_report(make_report(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
  endtask

  task automatic test_directed_cases();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    send_report(make_pads(0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'hFF));
    send_report(make_pads(1, 0, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 8'hFF));
    send_report(make_pads(1, 0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 8'h01));
    send_report(make_pads(1, 0, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 8'h00));
    send_report(make_pads(0, 0, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 8'hFF));
    // right pad out of idle takes finger one
    send_report(make_pads(0, 1, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 8'h80));
    send_report(make_pads(0, 1, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 8'h7F));
    send_report(make_pads(1, 1, 16'h0001, 16'hFFFE, 16'h0001, 16'h7FFE, 8'h55));
    send_report(make_pads(1, 0, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 8'hAA));
    send_report(make_pads(0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h11));
    // both pads at once out of idle keep the current order
    send_report(make_pads(1, 1, 16'h1234, 16'h8001, 16'h7FFF, 16'h0001, 8'h33));
    send_report(make_pads(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h44));
    send_report(make_pads(1, 0, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 8'h0F));
    send_report(make_pads(1, 1, 16'hC000, 16'h4000, 16'h4000, 16'hC000, 8'hF0));
    send_report(make_pads(0, 1, 16'h0000, 16'h0000, 16'h8001, 16'h7FFE, 8'h01));
    send_report(make_pads(0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h01));
    send_report(make_pads(1, 1, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 8'hFE));
    send_report(make_pads(0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'h02));
    wait_drained();
  endtask

  // Tap both pads together so both contact ids run past their 7-bit range
  task automatic test_contact_id_wrap();
    repeat (130) begin
      send_report(make_report(1'b1, 1'b1));
      send_report(make_report(1'b0, 1'b0));
    end
    wait_drained();
  endtask

  task automatic test_output_hold_off();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    hold_left = 60;
    play_noise(40);
    wait_drained();
  endtask

  task automatic test_random_gestures(input int target);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    while (reports_sent < target) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_gaps_on = 1'($urandom_range(0, 1));
        rx_gaps_on = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 4) == 0) play_noise($urandom_range(1, 6));
      else play_gesture();
    end
    wait_drained();
  endtask

  task automatic test_full_rate(input int target);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    while (reports_sent < target) play_gesture();
  endtask

  initial begin
    int waited;
    lead_is_left = 1'b1;
    last_pair = dtct_pkg::PAIR_NONE;
    for (int s = 0; s < 2; s++) begin
      slot_active[s] = 1'b0;
      slot_id[s] = '0;
      slot_pos[s] = '0;
    end
    touch_clock = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_contact_id_wrap();
    test_output_hold_off();
    test_random_gestures(720);
    test_full_rate(800);

    in_valid = 1'b0;
    waited = 0;
    while (pending_reports.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (pending_reports.size() != 0) begin
      $display("%0t: %0d results expected, actual none", $time, pending_reports.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
